// File: design/itp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and the control store of the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  typedef logic [3:0] upc_t;

  // Character codes that the sequencer tests for.
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // Step addresses of the control program.
  localparam upc_t S_IDLE      = 4'd0;
  localparam upc_t S_D_ALNUM   = 4'd1;
  localparam upc_t S_D_LPAREN  = 4'd2;
  localparam upc_t S_D_RPAREN  = 4'd3;
  localparam upc_t S_OP_CHK    = 4'd4;
  localparam upc_t S_OP_TEST   = 4'd5;
  localparam upc_t S_OP_POP    = 4'd6;
  localparam upc_t S_PUSH      = 4'd7;
  localparam upc_t S_EMIT_CHAR = 4'd8;
  localparam upc_t S_RP_CHK    = 4'd9;
  localparam upc_t S_RP_TEST   = 4'd10;
  localparam upc_t S_RP_POP    = 4'd11;
  localparam upc_t S_RP_DROP   = 4'd12;
  localparam upc_t S_FL_CHK    = 4'd13;
  localparam upc_t S_FL_POP    = 4'd14;
  localparam upc_t S_FINISH    = 4'd15;

  typedef enum logic [2:0] {
    UOP_NONE,
    UOP_ACCEPT,
    UOP_EMIT_CHAR,
    UOP_EMIT_TOP,
    UOP_DROP_TOP,
    UOP_PUSH,
    UOP_FINISH
  } uop_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_ALNUM,
    C_LPAREN,
    C_RPAREN,
    C_EMPTY,
    C_TOP_LPAREN,
    C_PREC_GT,
    C_FLUSH_DONE
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
  } ctrl_word_t;

  // Precedence coded without sign: the "none" level maps to 0.
  function automatic logic [1:0] prec_code(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_CARET) p = 2'd3;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Control store. A word jumps to its target when its condition holds,
  // else it falls through to the next step.
  function automatic ctrl_word_t ucode_rom(input upc_t step);
    ctrl_word_t w;
    unique case (step)
      S_IDLE:      w = '{UOP_ACCEPT,    C_NO_INPUT,   S_IDLE};
      S_D_ALNUM:   w = '{UOP_NONE,      C_ALNUM,      S_EMIT_CHAR};
      S_D_LPAREN:  w = '{UOP_NONE,      C_LPAREN,     S_PUSH};
      S_D_RPAREN:  w = '{UOP_NONE,      C_RPAREN,     S_RP_CHK};
      S_OP_CHK:    w = '{UOP_NONE,      C_EMPTY,      S_PUSH};
      S_OP_TEST:   w = '{UOP_NONE,      C_PREC_GT,    S_PUSH};
      S_OP_POP:    w = '{UOP_EMIT_TOP,  C_ALWAYS,     S_OP_CHK};
      S_PUSH:      w = '{UOP_PUSH,      C_ALWAYS,     S_FL_CHK};
      S_EMIT_CHAR: w = '{UOP_EMIT_CHAR, C_ALWAYS,     S_FL_CHK};
      S_RP_CHK:    w = '{UOP_NONE,      C_EMPTY,      S_FL_CHK};
      S_RP_TEST:   w = '{UOP_NONE,      C_TOP_LPAREN, S_RP_DROP};
      S_RP_POP:    w = '{UOP_EMIT_TOP,  C_ALWAYS,     S_RP_CHK};
      S_RP_DROP:   w = '{UOP_DROP_TOP,  C_ALWAYS,     S_FL_CHK};
      S_FL_CHK:    w = '{UOP_NONE,      C_FLUSH_DONE, S_FINISH};
      S_FL_POP:    w = '{UOP_EMIT_TOP,  C_ALWAYS,     S_FL_CHK};
      S_FINISH:    w = '{UOP_FINISH,    C_ALWAYS,     S_IDLE};
      default:     w = '{UOP_NONE,      C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: design/infix_to_postfix_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of a character stream to postfix order, run by a
// small control program over an operator stack memory.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata            tlast        tuser
// s_axis   in   [7:0] char_in    end_of_expr  -
// m_axis   out  [7:0] out_char   run_last     [0] overflow
//
// The step counter walks the control store one word per cycle while no emit
// stalls; every stack test reads the top entry from a register that is loaded
// from the stack memory.
// A result waits in a holding register until the next one or the end of the
// item decides its tlast, then moves to the output register; a full output
// register stalls the step that emits. Reset empties the stack at once.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  wire logic       s_axis_tlast,   // end_of_expr
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // [7:0] out_char
  output logic            m_axis_tlast,   // run_last
  output logic      [0:0] m_axis_tuser    // [0] overflow
);
  import itp_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    stack_mem [STACK_DEPTH];
  logic [7:0]    top_q;

  upc_t          upc_q, upc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    char_q, char_d;
  logic          last_q, last_d;

  logic          pend_valid_q, pend_valid_d;
  logic [7:0]    pend_char_q, pend_char_d;
  logic          pend_ovf_q, pend_ovf_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  ctrl_word_t    cw;
  logic          cond_ok;
  logic          stall;
  logic          out_free;
  logic          empty;
  logic          full;
  logic          push_en;
  logic [AW-1:0] top_addr;
  logic [AW-1:0] push_addr;

  assign cw        = ucode_rom(upc_q);
  assign empty     = (cnt_q == '0);
  assign full      = (cnt_q == CW'(STACK_DEPTH));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign top_addr  = AW'(cnt_q - CW'(1));
  assign push_addr = AW'(cnt_q);
  assign push_en   = (cw.op == UOP_PUSH) && !full;

  assign s_axis_tready = (upc_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

  // An emit that would displace a held result needs room at the output.
  always_comb begin
    stall = 1'b0;
    if (cw.op == UOP_EMIT_CHAR || cw.op == UOP_EMIT_TOP || cw.op == UOP_FINISH) begin
      stall = pend_valid_q && !out_free;
    end
  end

  always_comb begin
    unique case (cw.cond)
      C_NEVER:      cond_ok = 1'b0;
      C_ALWAYS:     cond_ok = 1'b1;
      C_NO_INPUT:   cond_ok = !s_axis_tvalid;
      C_ALNUM:      cond_ok = is_alnum(char_q);
      C_LPAREN:     cond_ok = (char_q == CH_LPAREN);
      C_RPAREN:     cond_ok = (char_q == CH_RPAREN);
      C_EMPTY:      cond_ok = empty;
      C_TOP_LPAREN: cond_ok = (top_q == CH_LPAREN);
      C_PREC_GT:    cond_ok = (prec_code(char_q) > prec_code(top_q));
      C_FLUSH_DONE: cond_ok = !last_q || empty;
      default:      cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    upc_d        = upc_q;
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    char_d       = char_q;
    last_d       = last_q;
    pend_valid_d = pend_valid_q;
    pend_char_d  = pend_char_q;
    pend_ovf_d   = pend_ovf_q;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (!stall) begin
      upc_d = cond_ok ? cw.target : upc_t'(upc_q + upc_t'(1));
      case (cw.op)
        UOP_ACCEPT: begin
          if (s_axis_tvalid) begin
            char_d = s_axis_tdata;
            last_d = s_axis_tlast;
          end
        end
        UOP_EMIT_CHAR, UOP_EMIT_TOP: begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_char_d  = pend_char_q;
            out_last_d  = 1'b0;
            out_ovf_d   = pend_ovf_q;
          end
          pend_valid_d = 1'b1;
          pend_char_d  = (cw.op == UOP_EMIT_TOP) ? top_q : char_q;
          pend_ovf_d   = ovf_q;
          if (cw.op == UOP_EMIT_TOP) begin
            cnt_d = cnt_q - CW'(1);
          end
        end
        UOP_DROP_TOP: begin
          cnt_d = cnt_q - CW'(1);
        end
        UOP_PUSH: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
        UOP_FINISH: begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_char_d   = pend_char_q;
            out_last_d   = 1'b1;
            out_ovf_d    = pend_ovf_q;
            pend_valid_d = 1'b0;
          end
          if (last_q) begin
            ovf_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q        <= S_IDLE;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      upc_q        <= upc_d;
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    last_q      <= last_d;
    pend_char_q <= pend_char_d;
    pend_ovf_q  <= pend_ovf_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  // Stack memory: one write port for pushes, the top entry read each cycle the stack is not empty.
  always_ff @(posedge clk_i) begin
    if (push_en && !stall) begin
      stack_mem[push_addr] <= char_q;
    end
    if (!empty) begin
      top_q <= stack_mem[top_addr];
    end
  end

endmodule
`default_nettype wire
